/* design/sbfr_pkg.sv */
// ----------------------------------------------------------------------------
// sbfr_pkg
// Shared types and constants for the serial-bus frame receiver.
// ----------------------------------------------------------------------------
package sbfr_pkg;

  localparam int PAYLOAD_BYTES = 23;
  localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int INDEX_W       = 5;
  localparam int COUNT_W       = 16;

  localparam logic [7:0] SYNC_RESET = 8'h0F;
  localparam logic [7:0] END_RESET  = 8'h00;

  // register select, taken from paddr[2]
  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_END  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COLLECT,
    ST_READ,
    ST_SHOW
  } sbfr_state_t;

endpackage

/* design/sbus_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// Frame sync on a received byte stream: waits for the sync byte, stores the
// payload in a RAM, checks the end byte and replays the payload as items.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  in_      | sink      | rx_byte[7:0]
//  out_     | source    | payload_byte[7:0], byte_index[4:0], last, frame_count[15:0]
//  cfg_     | APB slave | sync_byte @0x0, end_byte @0x4
//
// One cycle per input byte. A good end byte starts a burst of PAYLOAD_BYTES
// items, each a payload RAM read, then the output register, which holds the item
// through any out_ready stalls; no input is taken during the burst.
// Reset clears control state and the frame counter; the payload RAM is not
// cleared. out_ready low simply holds the current item.
module sbus_frame_receiver
  import sbfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_payload_byte,
  output logic [INDEX_W-1:0]   out_byte_index,
  output logic                 out_last,
  output logic [COUNT_W-1:0]   out_frame_count,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  sbfr_state_t        state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [COUNT_W-1:0] frames_r, frames_nxt;
  logic [7:0]         sync_r, end_r;
  logic [7:0]         mem [PAYLOAD_BYTES];
  logic [7:0]         mem_q;
  logic               mem_we, mem_re;
  logic               in_fire, cfg_wr, idx_last;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = {24'd0, (cfg_paddr[2] == REG_END) ? end_r : sync_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
      end_r  <= END_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SYNC) sync_r <= cfg_pwdata[7:0];
      else                          end_r  <= cfg_pwdata[7:0];
    end
  end

  assign in_fire  = in_valid & in_ready;
  assign idx_last = (rd_idx_r == ADDR_W'(PAYLOAD_BYTES - 1));

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    rd_idx_nxt = rd_idx_r;
    frames_nxt = frames_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_rx_byte == sync_r) begin
          state_nxt = ST_COLLECT;
          pos_nxt   = '0;
        end
      end
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (pos_r < POS_W'(PAYLOAD_BYTES)) begin
            mem_we  = 1'b1;
            pos_nxt = pos_r + POS_W'(1);
          end else begin
            // final byte: accept or drop the frame
            pos_nxt = '0;
            if (in_rx_byte == end_r) begin
              frames_nxt = frames_r + COUNT_W'(1);
              rd_idx_nxt = '0;
              state_nxt  = ST_READ;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
            state_nxt  = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= '0;
      rd_idx_r <= '0;
      frames_r <= '0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      rd_idx_r <= rd_idx_nxt;
      frames_r <= frames_nxt;
    end
  end

  // payload RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[pos_r[ADDR_W-1:0]] <= in_rx_byte;
    if (mem_re) mem_q <= mem[rd_idx_r];
  end

  assign out_payload_byte = mem_q;
  assign out_byte_index   = INDEX_W'(rd_idx_r);
  assign out_last         = idx_last;
  assign out_frame_count  = frames_r;

endmodule

/* design/sbfr_checker.sv */
// ----------------------------------------------------------------------------
// sbfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sbfr_checker
  import sbfr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_payload_byte,
  input logic [INDEX_W-1:0] out_byte_index,
  input logic               out_last,
  input logic [COUNT_W-1:0] out_frame_count
);

  // no input taken while a frame is being replayed
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted during frame replay");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_byte_index) && $stable(out_frame_count))
    else $error("stalled item changed");

  // items of a frame come in order with one frame count
  a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> ##1 out_valid
      && out_byte_index == $past(out_byte_index, 2) + INDEX_W'(1)
      && out_frame_count == $past(out_frame_count, 2))
    else $error("payload index or frame count out of sequence");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_byte_index == INDEX_W'(PAYLOAD_BYTES - 1))
    else $error("last flag on wrong index");

endmodule

bind sbus_frame_receiver sbfr_checker u_sbfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_payload_byte (out_payload_byte),
  .out_byte_index   (out_byte_index),
  .out_last         (out_last),
  .out_frame_count  (out_frame_count)
);
